@@ design/dcsig_pkg.sv @@
// dcsig_pkg: shared types, widths and the luma helper for the block signature compare
// depends on nothing; imported by dct_dc_block_pair_signature_compare
`timescale 1ns / 1ps

package dcsig_pkg;

	localparam int PIX_W      = 8;
	localparam int LUMA_W     = 24;
	localparam int RUN_W      = 26;
	localparam int SUM_W      = 28;
	localparam int CNT_W      = 17;
	localparam int CFG_W      = 12;
	localparam int ROW_W      = 11;
	localparam int REG_ROW_W  = 9;
	localparam int REG_COL_W  = 8;
	localparam int MAX_HEIGHT = 2048;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Q16 luma weights for red, green and blue
	localparam logic [15:0] WEIGHT_R = 16'd19595;
	localparam logic [15:0] WEIGHT_G = 16'd38470;
	localparam logic [15:0] WEIGHT_B = 16'd7471;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} bgr_t;

	// exact, unrounded luma; the maximum is 255 * 65536, which fits in 24 bits
	function automatic logic [LUMA_W-1:0] luma(input bgr_t px);
		logic [LUMA_W-1:0] y;
		y = LUMA_W'(WEIGHT_R) * LUMA_W'(px.red)
			+ LUMA_W'(WEIGHT_G) * LUMA_W'(px.green)
			+ LUMA_W'(WEIGHT_B) * LUMA_W'(px.blue);
		return y;
	endfunction

endpackage

@@ design/dct_dc_block_pair_signature_compare.sv @@
// dct_dc_block_pair_signature_compare: 4x4 luma block sums of two images, one signature
// bit per 4x8 region and image. depends on dcsig_pkg and dcsig_ram
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------------
//   in      | input     | in_valid / in_stall     | bgr bytes of both images, one pixel pair
//   out     | output    | out_valid / out_stall   | signature bits, mismatch, region, total, done
//   cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data (width, height)
//
// one pixel pair per clock while in_stall is low; the pixel that closes a region carries its
// result through s1 luma, s2 block sum read-modify-write, s3 compare and the output register.
// partial block sums live in one ram of MAX_WIDTH / 4 rows, read as a pixel enters s2, written as it leaves.
// reset clears position, running sums, left blocks and the mismatch count; the ram is not
// cleared since the first row of every band overwrites it.
// a stall on the output holds s2 only while it carries a result; pixels behind a held result wait too.
`timescale 1ns / 1ps

module dct_dc_block_pair_signature_compare
	import dcsig_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      blue_first,
	input  logic [PIX_W-1:0]      green_first,
	input  logic [PIX_W-1:0]      red_first,
	input  logic [PIX_W-1:0]      blue_second,
	input  logic [PIX_W-1:0]      green_second,
	input  logic [PIX_W-1:0]      red_second,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  sig_bit_first,
	output logic                  sig_bit_second,
	output logic                  mismatch,
	output logic [REG_ROW_W-1:0]  region_row,
	output logic [REG_COL_W-1:0]  region_col,
	output logic [CNT_W-1:0]      mismatch_total,
	output logic                  frame_done,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = COL_W + 1;
	localparam int NUM_BLOCKS = MAX_WIDTH / 4;
	localparam int BLK_W      = COL_W - 2;
	localparam int HGT_W      = ROW_W + 1;

	typedef struct packed {
		logic                 active;
		logic                 seg_end;
		logic [1:0]           band_row;
		logic [BLK_W-1:0]     blk;
		logic                 result;
		logic                 last;
		logic [REG_ROW_W-1:0] reg_row;
		logic [REG_COL_W-1:0] reg_col;
	} ctl_t;

	// configuration
	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;

	// position
	logic [COL_W-1:0] pixel_col_q;
	logic [ROW_W-1:0] pixel_row_q;

	// pipeline
	logic             s1_valid, s2_valid, s3_valid, out_valid_q;
	ctl_t             ctl_s1, ctl_s2, ctl_s3;
	bgr_t             px_first_s1, px_second_s1;
	logic [LUMA_W-1:0] y_first_s2, y_second_s2;
	logic [SUM_W-1:0] left_first_s3, left_second_s3, right_first_s3, right_second_s3;

	logic [RUN_W-1:0] run_first_q, run_second_q;
	logic [SUM_W-1:0] left_first_q, left_second_q;
	logic [CNT_W-1:0] count_q;

	logic                   sig_first_q, sig_second_q, mismatch_q, frame_done_q;
	logic [REG_ROW_W-1:0]   region_row_q;
	logic [REG_COL_W-1:0]   region_col_q;
	logic [CNT_W-1:0]       total_q;

	// flow control
	logic out_free, s3_move, s3_free, s2_move, s2_free, s1_move, s1_free, accept;

	assign out_free = !out_valid_q || !out_stall;
	assign s3_move  = s3_valid && out_free;
	assign s3_free  = !s3_valid || out_free;
	assign s2_free  = !s2_valid || !ctl_s2.result || s3_free;
	assign s2_move  = s2_valid && s2_free;
	assign s1_free  = !s1_valid || s2_free;
	assign s1_move  = s1_valid && s2_free;
	assign accept   = in_valid && s1_free;
	assign in_stall = !s1_free;
	assign cfg_ready = 1'b1;

	// effective frame size and position decode
	logic [WID_W-1:0] w_eff, act_w;
	logic [HGT_W-1:0] h_eff, act_h;
	logic [WID_W-1:0] col_next;
	logic [HGT_W-1:0] row_next;
	ctl_t             ctl_in;

	always_comb begin
		if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else if (image_width_q == '0) begin
			w_eff = WID_W'(1);
		end else begin
			w_eff = WID_W'(image_width_q);
		end
		if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HGT_W'(MAX_HEIGHT);
		end else if (image_height_q == '0) begin
			h_eff = HGT_W'(1);
		end else begin
			h_eff = HGT_W'(image_height_q);
		end
		act_w = {w_eff[WID_W-1:3], 3'b000};
		act_h = {h_eff[HGT_W-1:2], 2'b00};

		col_next = WID_W'(pixel_col_q) + WID_W'(1);
		row_next = HGT_W'(pixel_row_q) + HGT_W'(1);

		ctl_in.active   = (WID_W'(pixel_col_q) < act_w) && (HGT_W'(pixel_row_q) < act_h);
		ctl_in.seg_end  = pixel_col_q[1:0] == 2'b11;
		ctl_in.band_row = pixel_row_q[1:0];
		ctl_in.blk      = pixel_col_q[COL_W-1:2];
		ctl_in.result   = ctl_in.active && ctl_in.seg_end && (pixel_row_q[1:0] == 2'b11)
			&& ctl_in.blk[0];
		ctl_in.last     = (HGT_W'(pixel_row_q) == act_h - HGT_W'(1))
			&& (WID_W'(pixel_col_q) == act_w - WID_W'(1));
		ctl_in.reg_row  = REG_ROW_W'(pixel_row_q >> 2);
		ctl_in.reg_col  = REG_COL_W'(pixel_col_q >> 3);
	end

	// block sum ram: first image in the upper half, second in the lower
	logic                 ram_wr_en, ram_rd_en;
	logic [2*SUM_W-1:0]   ram_wr_data, ram_rd_data;
	logic [SUM_W-1:0]     seg_first, seg_second, blk_first, blk_second;

	assign ram_rd_en = s1_move && ctl_s1.active && ctl_s1.seg_end && (ctl_s1.band_row != 2'b00);
	assign ram_wr_en = s2_move && ctl_s2.active && ctl_s2.seg_end;

	always_comb begin
		seg_first  = SUM_W'(RUN_W'(run_first_q + RUN_W'(y_first_s2)));
		seg_second = SUM_W'(RUN_W'(run_second_q + RUN_W'(y_second_s2)));
		if (ctl_s2.band_row == 2'b00) begin
			blk_first  = seg_first;
			blk_second = seg_second;
		end else begin
			blk_first  = ram_rd_data[2*SUM_W-1:SUM_W] + seg_first;
			blk_second = ram_rd_data[SUM_W-1:0] + seg_second;
		end
		ram_wr_data = {blk_first, blk_second};
	end

	// the same block comes back no sooner than one row later, so reads never overlap writes
	dcsig_ram #(
		.WIDTH(2 * SUM_W),
		.DEPTH(NUM_BLOCKS)
	) u_block_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ctl_s2.blk),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ctl_s1.blk),
		.rd_data (ram_rd_data)
	);

	// compare and count
	logic             b_first, b_second, mm;
	logic [CNT_W-1:0] count_next;

	always_comb begin
		b_first  = left_first_s3 > right_first_s3;
		b_second = left_second_s3 > right_second_s3;
		mm       = b_first ^ b_second;
		if (mm && (count_q < CNT_MAX)) begin
			count_next = count_q + CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= CFG_W'(640);
			image_height_q <= CFG_W'(480);
			pixel_col_q    <= '0;
			pixel_row_q    <= '0;
			s1_valid       <= 1'b0;
			s2_valid       <= 1'b0;
			s3_valid       <= 1'b0;
			out_valid_q    <= 1'b0;
			run_first_q    <= '0;
			run_second_q   <= '0;
			left_first_q   <= '0;
			left_second_q  <= '0;
			count_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
					default: ;
				endcase
			end

			if (accept) begin
				if (col_next >= w_eff) begin
					pixel_col_q <= '0;
					if (row_next >= h_eff) begin
						pixel_row_q <= '0;
					end else begin
						pixel_row_q <= ROW_W'(row_next);
					end
				end else begin
					pixel_col_q <= COL_W'(col_next);
				end
			end

			if (s1_free) begin
				s1_valid <= accept;
			end
			if (s2_free) begin
				s2_valid <= s1_move;
			end
			if (s3_free) begin
				s3_valid <= s2_move && ctl_s2.result;
			end
			if (out_free) begin
				out_valid_q <= s3_move;
			end

			if (s2_move && ctl_s2.active) begin
				if (ctl_s2.seg_end) begin
					run_first_q  <= '0;
					run_second_q <= '0;
					if ((ctl_s2.band_row == 2'b11) && !ctl_s2.blk[0]) begin
						left_first_q  <= blk_first;
						left_second_q <= blk_second;
					end
				end else begin
					run_first_q  <= RUN_W'(seg_first);
					run_second_q <= RUN_W'(seg_second);
				end
			end

			if (s3_move) begin
				// clears after the transaction that closes the frame
				count_q <= ctl_s3.last ? '0 : count_next;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1       <= ctl_in;
			px_first_s1  <= '{blue: blue_first, green: green_first, red: red_first};
			px_second_s1 <= '{blue: blue_second, green: green_second, red: red_second};
		end
		if (s1_move) begin
			ctl_s2      <= ctl_s1;
			y_first_s2  <= luma(px_first_s1);
			y_second_s2 <= luma(px_second_s1);
		end
		if (s2_move && ctl_s2.result) begin
			ctl_s3          <= ctl_s2;
			left_first_s3   <= left_first_q;
			left_second_s3  <= left_second_q;
			right_first_s3  <= blk_first;
			right_second_s3 <= blk_second;
		end
		if (s3_move) begin
			sig_first_q  <= b_first;
			sig_second_q <= b_second;
			mismatch_q   <= mm;
			region_row_q <= ctl_s3.reg_row;
			region_col_q <= ctl_s3.reg_col;
			total_q      <= count_next;
			frame_done_q <= ctl_s3.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign sig_bit_first  = sig_first_q;
	assign sig_bit_second = sig_second_q;
	assign mismatch       = mismatch_q;
	assign region_row     = region_row_q;
	assign region_col     = region_col_q;
	assign mismatch_total = total_q;
	assign frame_done     = frame_done_q;

endmodule

@@ design/dcsig_ram.sv @@
// dcsig_ram: generic single-clock ram, one write port and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module dcsig_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for dct_dc_block_pair_signature_compare
// drives pixel pairs and register writes, predicts every region result; depends on dcsig_pkg
`timescale 1ns / 1ps

module tb_top
	import dcsig_pkg::*;
();

	localparam int BLK           = 4;
	localparam int REGION_W      = 2 * BLK;
	localparam int NUM_BLK       = 512;
	localparam int WIDTH_CAP     = 2048;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 400;

	typedef enum int {PAT_RANDOM, PAT_SAME, PAT_FLAT, PAT_SPLIT, PAT_EXTREME} pattern_t;

	typedef struct packed {
		logic                 sig_first;
		logic                 sig_second;
		logic                 differ;
		logic [REG_ROW_W-1:0] row;
		logic [REG_COL_W-1:0] col;
		logic [CNT_W-1:0]     total;
		logic                 done;
	} region_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     blue_first = '0;
	logic [PIX_W-1:0]     green_first = '0;
	logic [PIX_W-1:0]     red_first = '0;
	logic [PIX_W-1:0]     blue_second = '0;
	logic [PIX_W-1:0]     green_second = '0;
	logic [PIX_W-1:0]     red_second = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 sig_bit_first;
	logic                 sig_bit_second;
	logic                 mismatch;
	logic [REG_ROW_W-1:0] region_row;
	logic [REG_COL_W-1:0] region_col;
	logic [CNT_W-1:0]     mismatch_total;
	logic                 frame_done;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_index = 1'b0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// predicted block state
	int unsigned      width_reg = 640;
	int unsigned      height_reg = 480;
	int unsigned      next_col = 0;
	int unsigned      next_row = 0;
	logic [RUN_W-1:0] seg_first = '0;
	logic [RUN_W-1:0] seg_second = '0;
	logic [SUM_W-1:0] band_first [NUM_BLK];
	logic [SUM_W-1:0] band_second [NUM_BLK];
	logic [SUM_W-1:0] left_first = '0;
	logic [SUM_W-1:0] left_second = '0;
	logic [CNT_W-1:0] frame_mismatches = '0;
	region_result_t   expected_regions[$];

	region_result_t   seen_region;
	region_result_t   want_region;
	int               failures = 0;
	int               useful_items = 0;
	bit               idle_on = 1'b1;
	int unsigned      gap_pct = 20;
	logic [7:0]       flat_level = 8'd255;
	int unsigned      stall_left = 0;
	int unsigned      free_left = 0;

	dct_dc_block_pair_signature_compare #(.MAX_WIDTH(WIDTH_CAP)) dut (.*);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic logic [LUMA_W-1:0] pixel_luma(input bgr_t p);
		return LUMA_W'(19595 * int'(p.red) + 38470 * int'(p.green) + 7471 * int'(p.blue));
	endfunction

	// advances the predicted position by one pixel pair and queues a region result if one closes
	task automatic predict_pixel(input bgr_t p1, input bgr_t p2, output bit counted);
		int unsigned      w, h, act_w, act_h, blk;
		logic [SUM_W-1:0] s1, s2;
		region_result_t   r;
		w = (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
		if (w == 0) w = 1;
		h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		if (h == 0) h = 1;
		act_w = (w / REGION_W) * REGION_W;
		act_h = (h / BLK) * BLK;
		counted = (next_col < act_w) && (next_row < act_h);
		if (counted) begin
			seg_first = seg_first + RUN_W'(pixel_luma(p1));
			seg_second = seg_second + RUN_W'(pixel_luma(p2));
			if (next_col % BLK == BLK - 1) begin
				blk = (next_col / BLK) % NUM_BLK;
				if (next_row % BLK == 0) begin
					s1 = SUM_W'(seg_first);
					s2 = SUM_W'(seg_second);
				end else begin
					s1 = band_first[blk] + SUM_W'(seg_first);
					s2 = band_second[blk] + SUM_W'(seg_second);
				end
				band_first[blk] = s1;
				band_second[blk] = s2;
				seg_first = '0;
				seg_second = '0;
				if (next_row % BLK == BLK - 1) begin
					if (blk % 2 == 0) begin
						left_first = s1;
						left_second = s2;
					end else begin
						r.sig_first = left_first > s1;
						r.sig_second = left_second > s2;
						r.differ = r.sig_first ^ r.sig_second;
						r.done = (next_row == act_h - 1) && (next_col == act_w - 1);
						if (r.differ && frame_mismatches != CNT_MAX)
							frame_mismatches++;
						r.row = REG_ROW_W'(next_row / BLK);
						r.col = REG_COL_W'(next_col / REGION_W);
						r.total = frame_mismatches;
						expected_regions.push_back(r);
						if (r.done)
							frame_mismatches = '0;
					end
				end
			end
		end
		next_col++;
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
			if (next_row >= h)
				next_row = 0;
		end
	endtask

	task automatic make_pixels(input pattern_t pat, output bgr_t p1, output bgr_t p2);
		logic [7:0] hi, lo;
		logic [5:0] pick;
		p1 = bgr_t'(24'($urandom));
		p2 = bgr_t'(24'($urandom));
		case (pat)
			PAT_SAME: p2 = p1;
			PAT_FLAT: begin
				p1 = {3{flat_level}};
				p2 = p1;
			end
			// first image bright on the left half of the region, second bright on the right
			PAT_SPLIT: begin
				hi = 8'($urandom_range(255, 128));
				lo = 8'($urandom_range(127, 0));
				if (next_col % REGION_W < BLK) begin
					p1 = {3{hi}};
					p2 = {3{lo}};
				end else begin
					p1 = {3{lo}};
					p2 = {3{hi}};
				end
			end
			PAT_EXTREME: begin
				pick = 6'($urandom);
				p1 = {{8{pick[0]}}, {8{pick[1]}}, {8{pick[2]}}};
				p2 = {{8{pick[3]}}, {8{pick[4]}}, {8{pick[5]}}};
			end
			default: ;
		endcase
	endtask

	task automatic send_pixel(input pattern_t pat);
		bgr_t        p1, p2;
		bit          counted;
		int unsigned gap;
		if (idle_on && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(8, 1);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		make_pixels(pat, p1, p2);
		@(negedge clk);
		in_valid = 1'b1;
		blue_first = p1.blue;
		green_first = p1.green;
		red_first = p1.red;
		blue_second = p2.blue;
		green_second = p2.green;
		red_second = p2.red;
		do @(posedge clk); while (in_stall);
		predict_pixel(p1, p2, counted);
		if (counted)
			useful_items++;
	endtask

	task automatic send_pixels(input int unsigned n, input pattern_t pat);
		repeat (n) send_pixel(pat);
	endtask

	// pads the stream up to the start of a band, or of a frame
	task automatic align(input bit whole_frame, input pattern_t pat);
		while (next_col != 0 || (whole_frame ? next_row != 0 : next_row % BLK != 0))
			send_pixel(pat);
	endtask

	task automatic send_frames(input int unsigned n, input pattern_t pat);
		repeat (n) begin
			send_pixel(pat);
			align(1'b1, pat);
		end
	endtask

	task automatic stop_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// no register write while a pixel may still be in flight
	task automatic wait_idle();
		stop_input();
		while (expected_regions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_IMAGE_WIDTH)
			width_reg = value & 32'hFFF;
		else
			height_reg = value & 32'hFFF;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_size(input int unsigned w, input int unsigned h);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	task automatic note_failure(input string what, input region_result_t want,
			input region_result_t got);
		failures++;
		if (failures <= 10)
			$display("%s: expected sig %b/%b mm %b row %0d col %0d total %0d done %b",
				what, want.sig_first, want.sig_second, want.differ, want.row, want.col,
				want.total, want.done,
				"  got sig %b/%b mm %b row %0d col %0d total %0d done %b",
				got.sig_first, got.sig_second, got.differ, got.row, got.col,
				got.total, got.done);
	endtask

	// result stall in bursts, with long free stretches now and then
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (free_left != 0) begin
			out_stall = 1'b0;
			free_left--;
		end else if (idle_on && $urandom_range(2) == 0) begin
			out_stall = 1'b1;
			stall_left = $urandom_range(8, 1) - 1;
		end else begin
			out_stall = 1'b0;
			free_left = ($urandom_range(7) == 0) ? $urandom_range(200, 50) : $urandom_range(30, 1);
		end
	end

	// every accepted result transaction is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_region = {sig_bit_first, sig_bit_second, mismatch, region_row, region_col,
				mismatch_total, frame_done};
			if (expected_regions.size() == 0) begin
				note_failure("unexpected result", '0, seen_region);
			end else begin
				want_region = expected_regions.pop_front();
				if (seen_region !== want_region)
					note_failure("result mismatch", want_region, seen_region);
			end
		end
	end

	// start of the first row at the reset size of 640 x 480; the next size change wraps it
	task automatic test_reset_size();
		send_pixels(16, PAT_RANDOM);
	endtask

	task automatic test_region_extremes();
		set_size(8, 4);
		align(1'b1, PAT_RANDOM);
		send_pixels(32, PAT_SPLIT);
		flat_level = 8'd255;
		send_pixels(32, PAT_FLAT);
		flat_level = 8'd0;
		send_pixels(32, PAT_FLAT);
		send_pixels(32, PAT_EXTREME);
	endtask

	// zero, too small and non-multiple sizes; partial edges give nothing
	task automatic test_size_limits();
		set_size(0, 0);
		send_frames(6, PAT_RANDOM);
		set_size(7, 3);
		send_frames(1, PAT_RANDOM);
		set_size(8, 3);
		send_frames(1, PAT_EXTREME);
		set_size(7, 4);
		send_frames(1, PAT_RANDOM);
		set_size(13, 7);
		send_frames(2, PAT_RANDOM);
	endtask

	// width above the limit; only the start of the first row goes out
	task automatic test_wide_frame();
		set_size(4095, 4);
		send_pixels(64, PAT_RANDOM);
	endtask

	// height above the limit; the narrow width wraps the long row and the band is closed
	task automatic test_tall_frame();
		set_size(8, 4095);
		align(1'b0, PAT_RANDOM);
	endtask

	// size changes while a frame is under way; the position wraps or carries on
	task automatic test_midframe_write();
		set_size(16, 16);
		send_pixels(16 * 8, PAT_RANDOM);
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, 8);
		align(1'b1, PAT_RANDOM);
		send_pixels(16 * BLK, PAT_SAME);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 24);
		align(1'b1, PAT_RANDOM);
		send_frames(1, PAT_RANDOM);
	endtask

	task automatic test_random_frames();
		int unsigned w, h, sel;
		pattern_t    pat;
		useful_items = 0;
		while (useful_items < RANDOM_ITEMS) begin
			sel = $urandom_range(9);
			w = (sel == 0) ? $urandom_range(7, 0) : $urandom_range(24, 8);
			h = (sel == 1) ? $urandom_range(3, 0) : $urandom_range(12, 4);
			case ($urandom_range(3))
				0: gap_pct = 0;
				1: gap_pct = 5;
				2: gap_pct = 25;
				default: gap_pct = 50;
			endcase
			pat = pattern_t'($urandom_range(4));
			flat_level = 8'($urandom);
			wait_idle();
			sel = $urandom_range(3);
			if (sel != 1)
				write_reg(REG_IMAGE_WIDTH, w);
			if (sel != 2)
				write_reg(REG_IMAGE_HEIGHT, h);
			// end some phases mid-frame, but always on a band boundary
			if ($urandom_range(2) == 0) begin
				send_pixels($urandom_range(2 * w * h + 1, 1), pat);
				align(1'b0, pat);
			end else begin
				send_frames($urandom_range(3, 1), pat);
			end
		end
	endtask

	task automatic test_quiet_drain();
		idle_on = 1'b0;
		gap_pct = 0;
		set_size(32, 8);
		send_frames(1, PAT_RANDOM);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_size();
		test_region_extremes();
		test_size_limits();
		test_wide_frame();
		test_tall_frame();
		test_midframe_write();
		test_random_frames();
		test_quiet_drain();
		stop_input();
		while (expected_regions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

@@ dct_dc_block_pair_signature_compare.f @@
design/dcsig_pkg.sv
design/dcsig_ram.sv
design/dct_dc_block_pair_signature_compare.sv
bench/tb_top.sv
